// ===== hw/rtl/mic_pkg.sv =====
// Shared types and constants of the multiprocessor interrupt controller.
// Used by the front end, command queue, execution back end and top level.
// Depends on nothing.
package mic_pkg;

	// Default number of CPUs and the number of CPUs with interrupt outputs
	localparam int CPUS_DEF  = 4;
	localparam int IRQ_LINES = 4;

	// Field widths fixed by the bus and register layout
	localparam int DATA_W = 64;
	localparam int LINE_W = 6;
	localparam int REQ_W  = 2;
	localparam int BANK_W = 2;
	localparam int CNT_W  = 3;

	// Command queue depth between front and back end
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Bit 28 of a MISC write: NXM acknowledge, accepted without effect
	localparam int NXM_BIT = 28;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_ASSERT   = 3'd2,
		OP_DEASSERT = 3'd3,
		OP_TICK     = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		REG_CSR  = 4'd0,
		REG_MISC = 4'd1,
		REG_AAR  = 4'd2,
		REG_DIM  = 4'd3,
		REG_DIR  = 4'd4,
		REG_DRIR = 4'd5,
		REG_IPIR = 4'd6,
		REG_ITIR = 4'd7,
		REG_IPIQ = 4'd8
	} reg_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNIMP = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_BANK  = 2'd3
	} err_t;

	// Work for the back end after classification
	typedef enum logic [3:0] {
		CMD_NONE    = 4'd0,
		CMD_RD_MISC = 4'd1,
		CMD_RD_DIM  = 4'd2,
		CMD_RD_DIR  = 4'd3,
		CMD_RD_DRIR = 4'd4,
		CMD_RD_IPIR = 4'd5,
		CMD_RD_ITIR = 4'd6,
		CMD_WR_DIM  = 4'd7,
		CMD_DEV_SET = 4'd8,
		CMD_DEV_CLR = 4'd9,
		CMD_PEND    = 4'd10
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [BANK_W-1:0]     bank;
		logic [DATA_W-1:0]     wdata;
		logic [LINE_W-1:0]     line;
		logic [REQ_W-1:0]      req;
		logic [IRQ_LINES-1:0]  ipi_set;
		logic [IRQ_LINES-1:0]  ipi_clr;
		logic [IRQ_LINES-1:0]  tmr_set;
		logic [IRQ_LINES-1:0]  tmr_clr;
		logic [IRQ_LINES-1:0]  act;
		err_t                  err;
	} cmd_t;

endpackage

// ===== hw/rtl/mic_front.sv =====
// Front end: holds the active CPU count, accepts and classifies requests.
// Produces one cmd_t per transfer for the command queue; uses mic_pkg.
module mic_front import mic_pkg::*; #(
	parameter int MASK_CPUS = IRQ_LINES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           op,
	input  logic [3:0]           reg_code,
	input  logic [LINE_W-1:0]    bank_cpu,
	input  logic [DATA_W-1:0]    wdata,
	input  logic [LINE_W-1:0]    device_line,
	input  logic [REQ_W-1:0]     requester_cpu,
	input  logic                 q_full,
	output logic                 q_wr,
	output cmd_t                 q_cmd
);

	localparam logic [CNT_W-1:0] LIM = CNT_W'(MASK_CPUS);

	logic [CNT_W-1:0]     active_q;
	logic [CNT_W-1:0]     eff_n;
	logic [IRQ_LINES-1:0] act;
	logic                 bank_ok;

	// Hold the active CPU count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(IRQ_LINES);
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// Clamp the count to one up to the number of present CPUs
	always_comb begin
		eff_n = active_q;
		if (eff_n == '0) eff_n = CNT_W'(1);
		if (eff_n > LIM) eff_n = LIM;
		for (int i = 0; i < IRQ_LINES; i++) begin
			act[i] = (CNT_W'(i) < eff_n);
		end
	end

	assign bank_ok  = (bank_cpu < LINE_W'(eff_n));
	assign in_ready = !q_full;
	assign q_wr     = in_valid && in_ready;

	// Classify the request into a back-end command and an error code
	always_comb begin
		q_cmd         = '0;
		q_cmd.kind    = CMD_NONE;
		q_cmd.err     = ERR_OK;
		q_cmd.bank    = bank_cpu[BANK_W-1:0];
		q_cmd.wdata   = wdata;
		q_cmd.line    = device_line;
		q_cmd.req     = requester_cpu;
		q_cmd.act     = act;
		unique case (op_t'(op))
			OP_READ: begin
				unique case (reg_t'(reg_code))
					REG_CSR, REG_AAR: q_cmd.kind = CMD_NONE;
					REG_MISC: q_cmd.kind = CMD_RD_MISC;
					REG_DIM: begin
						if (bank_ok) q_cmd.kind = CMD_RD_DIM;
						else q_cmd.err = ERR_BANK;
					end
					REG_DIR: begin
						if (bank_ok) q_cmd.kind = CMD_RD_DIR;
						else q_cmd.err = ERR_BANK;
					end
					REG_DRIR: q_cmd.kind = CMD_RD_DRIR;
					REG_IPIR: q_cmd.kind = CMD_RD_IPIR;
					REG_ITIR: q_cmd.kind = CMD_RD_ITIR;
					default:  q_cmd.err  = ERR_UNIMP;
				endcase
			end
			OP_WRITE: begin
				unique case (reg_t'(reg_code))
					REG_MISC: begin
						// set IPI, then clear IPI, then clear timer
						q_cmd.kind    = CMD_PEND;
						q_cmd.ipi_set = wdata[15:12] & act;
						q_cmd.ipi_clr = wdata[11:8] & act;
						q_cmd.tmr_clr = wdata[7:4] & act;
						if (wdata[15:4] == '0 && !wdata[NXM_BIT]) q_cmd.err = ERR_UNIMP;
					end
					REG_DIM: begin
						if (bank_ok) q_cmd.kind = CMD_WR_DIM;
						else q_cmd.err = ERR_BANK;
					end
					REG_IPIR, REG_ITIR, REG_IPIQ: begin
						if (wdata == '0) begin
							q_cmd.err = ERR_EMPTY;
						end else begin
							q_cmd.kind = CMD_PEND;
							case (reg_t'(reg_code))
								REG_IPIR: q_cmd.ipi_clr = wdata[IRQ_LINES-1:0] & act;
								REG_ITIR: q_cmd.tmr_clr = wdata[IRQ_LINES-1:0] & act;
								default:  q_cmd.ipi_set = wdata[IRQ_LINES-1:0] & act;
							endcase
						end
					end
					default: q_cmd.err = ERR_UNIMP;
				endcase
			end
			OP_ASSERT:   q_cmd.kind = CMD_DEV_SET;
			OP_DEASSERT: q_cmd.kind = CMD_DEV_CLR;
			OP_TICK: begin
				q_cmd.kind    = CMD_PEND;
				q_cmd.tmr_set = act;
			end
			default: q_cmd.err = ERR_UNIMP;
		endcase
	end

endmodule

// ===== hw/rtl/mic_queue.sv =====
// Two-entry command queue between front end and back end.
// Stores mic_pkg::cmd_t entries; uses mic_pkg.
module mic_queue import mic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (wr) slot_q[wr_ptr_q] <= wr_cmd;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr && !rd) cnt_q <= cnt_q + QCNT_W'(1);
			else if (rd && !wr) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr)
		else $error("write into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_valid |-> !rd)
		else $error("read from empty queue");
`endif

endmodule

// ===== hw/rtl/mic_back.sv =====
// Back end: holds masks, raw requests and pending bits, executes commands
// and registers one result per command. Uses mic_pkg.
module mic_back import mic_pkg::*; #(
	parameter int MASK_CPUS = IRQ_LINES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cmd_t                 q_cmd,
	output logic                 q_rd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    rdata,
	output logic [IRQ_LINES-1:0] device_irq_lines,
	output logic [IRQ_LINES-1:0] timer_irq_lines,
	output logic [IRQ_LINES-1:0] ipi_irq_lines,
	output logic [1:0]           error
);

	localparam int IDX_W = (MASK_CPUS > 1) ? $clog2(MASK_CPUS) : 1;

	logic [DATA_W-1:0]    mask_q [MASK_CPUS];
	logic [DATA_W-1:0]    mask_next [MASK_CPUS];
	logic [DATA_W-1:0]    raw_q;
	logic [DATA_W-1:0]    raw_next;
	logic [IRQ_LINES-1:0] ipi_q;
	logic [IRQ_LINES-1:0] ipi_next;
	logic [IRQ_LINES-1:0] tmr_q;
	logic [IRQ_LINES-1:0] tmr_next;
	logic [IRQ_LINES-1:0] dev_next;
	logic [DATA_W-1:0]    rd_next;
	logic [DATA_W-1:0]    line_bit;
	logic [DATA_W-1:0]    sel_mask;
	logic [IDX_W-1:0]     bank_idx;
	logic                 fire;

	logic                 out_valid_q;
	logic [DATA_W-1:0]    rdata_q;
	logic [IRQ_LINES-1:0] dev_lines_q;
	logic [IRQ_LINES-1:0] tmr_lines_q;
	logic [IRQ_LINES-1:0] ipi_lines_q;
	err_t                 err_q;

	// Execute when a command waits and the result slot is free or draining
	assign fire     = q_valid && (!out_valid_q || out_ready);
	assign q_rd     = fire;
	assign bank_idx = q_cmd.bank[IDX_W-1:0];
	assign line_bit = DATA_W'(1) << q_cmd.line;
	assign sel_mask = mask_q[bank_idx];

	// Form the state after this command
	always_comb begin
		raw_next = raw_q;
		ipi_next = ipi_q;
		tmr_next = tmr_q;
		case (q_cmd.kind)
			CMD_DEV_SET: raw_next = raw_q | line_bit;
			CMD_DEV_CLR: raw_next = raw_q & ~line_bit;
			CMD_PEND: begin
				ipi_next = (ipi_q | q_cmd.ipi_set) & ~q_cmd.ipi_clr;
				tmr_next = (tmr_q | q_cmd.tmr_set) & ~q_cmd.tmr_clr;
			end
			default: ;
		endcase
		for (int i = 0; i < MASK_CPUS; i++) begin
			mask_next[i] = (q_cmd.kind == CMD_WR_DIM && bank_idx == IDX_W'(i))
				? q_cmd.wdata : mask_q[i];
		end
	end

	// Device lines from the updated masks and raw vector
	always_comb begin
		dev_next = '0;
		for (int i = 0; i < IRQ_LINES; i++) begin
			if (i < MASK_CPUS) dev_next[i] = |(mask_next[i] & raw_next);
		end
		dev_next = dev_next & q_cmd.act;
	end

	// Select read data
	always_comb begin
		case (q_cmd.kind)
			CMD_RD_MISC: rd_next = {{(DATA_W-12){1'b0}}, ipi_q, tmr_q, 2'b00, q_cmd.req};
			CMD_RD_DIM:  rd_next = sel_mask;
			CMD_RD_DIR:  rd_next = sel_mask & raw_q;
			CMD_RD_DRIR: rd_next = raw_q;
			CMD_RD_IPIR: rd_next = DATA_W'(ipi_q);
			CMD_RD_ITIR: rd_next = DATA_W'(tmr_q);
			default:     rd_next = '0;
		endcase
	end

	// Commit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MASK_CPUS; i++) mask_q[i] <= '0;
			raw_q <= '0;
			ipi_q <= '0;
			tmr_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < MASK_CPUS; i++) mask_q[i] <= mask_next[i];
			raw_q <= raw_next;
			ipi_q <= ipi_next;
			tmr_q <= tmr_next;
		end
	end

	// Hold the result until the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rdata_q     <= rd_next;
			dev_lines_q <= dev_next;
			tmr_lines_q <= tmr_next & q_cmd.act;
			ipi_lines_q <= ipi_next & q_cmd.act;
			err_q       <= q_cmd.err;
		end
	end

	assign out_valid        = out_valid_q;
	assign rdata            = rdata_q;
	assign device_irq_lines = dev_lines_q;
	assign timer_irq_lines  = tmr_lines_q;
	assign ipi_irq_lines    = ipi_lines_q;
	assign error            = err_q;

`ifndef SYNTHESIS
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q != ERR_OK) |-> (rdata_q == '0))
		else $error("error result carries read data");
	a_read_keeps_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (q_cmd.kind == CMD_RD_MISC || q_cmd.kind == CMD_RD_IPIR ||
		q_cmd.kind == CMD_RD_ITIR)) |=> ($stable(ipi_q) && $stable(tmr_q)))
		else $error("read changed pending bits");
	a_raw_only_dev: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_cmd.kind != CMD_DEV_SET && q_cmd.kind != CMD_DEV_CLR)
		|=> $stable(raw_q))
		else $error("raw vector changed without device event");
`endif

endmodule

// ===== hw/rtl/multiprocessor_interrupt_controller.sv =====
// Top level of the multiprocessor interrupt controller.
// Instantiates mic_front, mic_queue and mic_back; uses mic_pkg.
//
// Interrupt controller for up to four CPUs: per-CPU 64-bit device masks,
// the raw device request vector, and per-CPU IPI and timer pending bits.
// Every transfer on the input channel (bus read, bus write, device line
// assert or deassert, timer tick) yields exactly one result transfer with
// read data, the per-CPU interrupt lines after the operation and an error
// code. One item is taken per clock while the queue is not full: the front
// end classifies it into a two-entry command queue and the back end
// executes one command per clock, while its output register is free or
// draining, into that register; each command is stored in the queue and
// its result then in the output register. The queue absorbs output stalls. There is
// no clearing pass after reset. The active CPU count is written through
// the cfg channel and must only change while no item is in flight.
module multiprocessor_interrupt_controller import mic_pkg::*; #(
	parameter int CPUS = CPUS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           op,
	input  logic [3:0]           reg_code,
	input  logic [LINE_W-1:0]    bank_cpu,
	input  logic [DATA_W-1:0]    wdata,
	input  logic [LINE_W-1:0]    device_line,
	input  logic [REQ_W-1:0]     requester_cpu,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    rdata,
	output logic [IRQ_LINES-1:0] device_irq_lines,
	output logic [IRQ_LINES-1:0] timer_irq_lines,
	output logic [IRQ_LINES-1:0] ipi_irq_lines,
	output logic [1:0]           error
);

	// Only the first four CPUs have masks and interrupt lines
	localparam int MASK_CPUS = (CPUS < IRQ_LINES) ? CPUS : IRQ_LINES;

	logic q_full;
	logic q_wr;
	logic q_rd;
	logic q_valid;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	mic_front #(
		.MASK_CPUS(MASK_CPUS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.reg_code     (reg_code),
		.bank_cpu     (bank_cpu),
		.wdata        (wdata),
		.device_line  (device_line),
		.requester_cpu(requester_cpu),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_cmd        (wr_cmd)
	);

	mic_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_cmd  (wr_cmd),
		.full    (q_full),
		.rd      (q_rd),
		.rd_valid(q_valid),
		.rd_cmd  (rd_cmd)
	);

	mic_back #(
		.MASK_CPUS(MASK_CPUS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (rd_cmd),
		.q_rd            (q_rd),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.rdata           (rdata),
		.device_irq_lines(device_irq_lines),
		.timer_irq_lines (timer_irq_lines),
		.ipi_irq_lines   (ipi_irq_lines),
		.error           (error)
	);

endmodule

// ===== verif/multiprocessor_interrupt_controller_tb.sv =====
// Self-checking testbench for the multiprocessor interrupt controller.
// Depends on mic_pkg and multiprocessor_interrupt_controller; nothing else.
// A clocked driver feeds queued bus accesses and events, a clocked monitor checks every result.
module multiprocessor_interrupt_controller_tb import mic_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Codes outside the implemented ranges
	localparam logic [2:0] OP_CODE_LAST  = 3'd7;
	localparam logic [3:0] REG_CODE_LAST = 4'hF;
	localparam int         PHASE_ITEMS   = 55;
	localparam int         LONG_HOLD     = 80;

	typedef struct packed {
		logic [2:0]        op;
		logic [3:0]        reg_code;
		logic [LINE_W-1:0] bank_cpu;
		logic [DATA_W-1:0] wdata;
		logic [LINE_W-1:0] device_line;
		logic [REQ_W-1:0]  requester_cpu;
	} ctl_request_t;

	typedef struct packed {
		logic [DATA_W-1:0]    rdata;
		logic [IRQ_LINES-1:0] device_irq_lines;
		logic [IRQ_LINES-1:0] timer_irq_lines;
		logic [IRQ_LINES-1:0] ipi_irq_lines;
		err_t                 error;
	} ctl_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [2:0]           op = '0;
	logic [3:0]           reg_code = '0;
	logic [LINE_W-1:0]    bank_cpu = '0;
	logic [DATA_W-1:0]    wdata = '0;
	logic [LINE_W-1:0]    device_line = '0;
	logic [REQ_W-1:0]     requester_cpu = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    rdata;
	logic [IRQ_LINES-1:0] device_irq_lines;
	logic [IRQ_LINES-1:0] timer_irq_lines;
	logic [IRQ_LINES-1:0] ipi_irq_lines;
	logic [1:0]           error;

	// Shadow copy of the controller state
	logic [CNT_W-1:0]     shadow_active_cpus = CNT_W'(4);
	logic [DATA_W-1:0]    shadow_mask [4];
	logic [DATA_W-1:0]    shadow_raw = '0;
	logic [IRQ_LINES-1:0] shadow_ipi = '0;
	logic [IRQ_LINES-1:0] shadow_tmr = '0;

	ctl_request_t pending_requests [$];
	ctl_result_t  expected_results [$];
	ctl_request_t offered_req;
	ctl_result_t  oldest_result;
	int           send_gap = 0;
	int           stall_left = 0;
	int           hold_seen = 0;
	int           hold_req_count = 0;
	int           fail_count = 0;
	logic         sender_quiet = 1'b0;
	logic         receiver_quiet = 1'b0;

	multiprocessor_interrupt_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.reg_code(reg_code),
		.bank_cpu(bank_cpu),
		.wdata(wdata),
		.device_line(device_line),
		.requester_cpu(requester_cpu),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rdata(rdata),
		.device_irq_lines(device_irq_lines),
		.timer_irq_lines(timer_irq_lines),
		.ipi_irq_lines(ipi_irq_lines),
		.error(error)
	);

	always #2 clk = ~clk;

	// Apply one access or event to the shadow state and return the lines and data
	function automatic ctl_result_t predict_controller_step(ctl_request_t r);
		ctl_result_t          res;
		int unsigned          n;
		logic [IRQ_LINES-1:0] act;
		logic                 bank_ok;
		n = shadow_active_cpus;
		if (n < 1) n = 1;
		if (n > 4) n = 4;
		act = IRQ_LINES'((1 << n) - 1);
		bank_ok = (r.bank_cpu < n);
		res = '0;
		res.error = ERR_OK;
		case (r.op)
			OP_READ: begin
				case (r.reg_code)
					REG_CSR, REG_AAR: res.rdata = '0;
					REG_MISC: res.rdata = {52'd0, shadow_ipi, shadow_tmr, 2'b00, r.requester_cpu};
					REG_DIM: begin
						if (bank_ok) res.rdata = shadow_mask[r.bank_cpu[1:0]];
						else res.error = ERR_BANK;
					end
					REG_DIR: begin
						if (bank_ok) res.rdata = shadow_mask[r.bank_cpu[1:0]] & shadow_raw;
						else res.error = ERR_BANK;
					end
					REG_DRIR: res.rdata = shadow_raw;
					REG_IPIR: res.rdata = {60'd0, shadow_ipi};
					REG_ITIR: res.rdata = {60'd0, shadow_tmr};
					default: res.error = ERR_UNIMP;
				endcase
			end
			OP_WRITE: begin
				case (r.reg_code)
					REG_MISC: begin
						// set IPIs first, then clear IPIs, then clear timers
						shadow_ipi = shadow_ipi | (r.wdata[15:12] & act);
						shadow_ipi = shadow_ipi & ~(r.wdata[11:8] & act);
						shadow_tmr = shadow_tmr & ~(r.wdata[7:4] & act);
						if (r.wdata[15:4] == '0 && !r.wdata[NXM_BIT]) res.error = ERR_UNIMP;
					end
					REG_DIM: begin
						if (bank_ok) shadow_mask[r.bank_cpu[1:0]] = r.wdata;
						else res.error = ERR_BANK;
					end
					REG_IPIR: begin
						if (r.wdata == '0) res.error = ERR_EMPTY;
						else shadow_ipi = shadow_ipi & ~(r.wdata[3:0] & act);
					end
					REG_ITIR: begin
						if (r.wdata == '0) res.error = ERR_EMPTY;
						else shadow_tmr = shadow_tmr & ~(r.wdata[3:0] & act);
					end
					REG_IPIQ: begin
						if (r.wdata == '0) res.error = ERR_EMPTY;
						else shadow_ipi = shadow_ipi | (r.wdata[3:0] & act);
					end
					default: res.error = ERR_UNIMP;
				endcase
			end
			OP_ASSERT: shadow_raw[r.device_line] = 1'b1;
			OP_DEASSERT: shadow_raw[r.device_line] = 1'b0;
			OP_TICK: shadow_tmr = shadow_tmr | act;
			default: res.error = ERR_UNIMP;
		endcase
		for (int i = 0; i < 4; i++) begin
			if (i < n && (shadow_mask[i] & shadow_raw) != '0) res.device_irq_lines[i] = 1'b1;
		end
		res.timer_irq_lines = shadow_tmr & act;
		res.ipi_irq_lines = shadow_ipi & act;
		return res;
	endfunction

	// Mostly back-to-back, sometimes a few cycles, rarely a long gap
	function automatic int draw_idle_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic logic [DATA_W-1:0] draw_data_word();
		logic [DATA_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
			3: w = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
			4: w = DATA_W'($urandom_range(0, 15));
			default: w = {$urandom(), $urandom()};
		endcase
		return w;
	endfunction

	function automatic ctl_request_t random_ctl_request();
		ctl_request_t r;
		int unsigned  pick;
		r.requester_cpu = REQ_W'($urandom_range(0, 3));
		r.device_line = LINE_W'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < 60) r.bank_cpu = LINE_W'($urandom_range(0, 3));
		else if (pick < 85) r.bank_cpu = LINE_W'($urandom_range(0, 7));
		else r.bank_cpu = LINE_W'($urandom_range(0, 63));
		r.wdata = draw_data_word();
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			r.op = OP_READ;
			if ($urandom_range(0, 9) == 0) r.reg_code = 4'($urandom_range(9, 15));
			else r.reg_code = 4'($urandom_range(REG_CSR, REG_IPIQ));
		end else if (pick < 65) begin
			r.op = OP_WRITE;
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				// MISC write: random set/clear nibbles, occasionally the acknowledge bit
				r.reg_code = REG_MISC;
				if ($urandom_range(0, 3) != 0) r.wdata[15:4] = 12'($urandom_range(0, 4095));
				else r.wdata[15:4] = '0;
				r.wdata[NXM_BIT] = $urandom_range(0, 3) == 0;
			end else if (pick < 45) begin
				r.reg_code = REG_DIM;
			end else if (pick < 75) begin
				r.reg_code = 4'($urandom_range(REG_IPIR, REG_IPIQ));
				if ($urandom_range(0, 2) != 0) r.wdata = DATA_W'($urandom_range(1, 15));
			end else begin
				r.reg_code = 4'($urandom_range(0, 15));
			end
		end else if (pick < 77) begin
			r.op = OP_ASSERT;
			r.reg_code = 4'($urandom_range(0, 15));
		end else if (pick < 87) begin
			r.op = OP_DEASSERT;
			r.reg_code = 4'($urandom_range(0, 15));
		end else if (pick < 95) begin
			r.op = OP_TICK;
			r.reg_code = 4'($urandom_range(0, 15));
		end else begin
			r.op = 3'($urandom_range(5, OP_CODE_LAST));
			r.reg_code = 4'($urandom_range(0, 15));
		end
		return r;
	endfunction

	task automatic queue_access(input logic [2:0] o, input logic [3:0] rc,
			input logic [LINE_W-1:0] bank, input logic [DATA_W-1:0] w,
			input logic [LINE_W-1:0] line, input logic [REQ_W-1:0] req);
		ctl_request_t r;
		r.op = o;
		r.reg_code = rc;
		r.bank_cpu = bank;
		r.wdata = w;
		r.device_line = line;
		r.requester_cpu = req;
		pending_requests.push_back(r);
	endtask

	// Block until every queued access is sent and every result has come back
	task automatic wait_until_drained();
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active_cpus(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		shadow_active_cpus = value;
		cfg_valid <= 1'b0;
	endtask

	// Driver: offer the next queued access, hold it until the transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_controller_step(offered_req));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					offered_req = pending_requests.pop_front();
					op <= offered_req.op;
					reg_code <= offered_req.reg_code;
					bank_cpu <= offered_req.bank_cpu;
					wdata <= offered_req.wdata;
					device_line <= offered_req.device_line;
					requester_cpu <= offered_req.requester_cpu;
					in_valid <= 1'b1;
					send_gap = sender_quiet ? 0 : draw_idle_cycles();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: rdata %h error %0d", rdata, error);
					fail_count++;
				end else begin
					oldest_result = expected_results.pop_front();
					if (rdata !== oldest_result.rdata) begin
						$error("rdata: expected %h, got %h", oldest_result.rdata, rdata);
						fail_count++;
					end
					if (device_irq_lines !== oldest_result.device_irq_lines) begin
						$error("device_irq_lines: expected %b, got %b",
							oldest_result.device_irq_lines, device_irq_lines);
						fail_count++;
					end
					if (timer_irq_lines !== oldest_result.timer_irq_lines) begin
						$error("timer_irq_lines: expected %b, got %b",
							oldest_result.timer_irq_lines, timer_irq_lines);
						fail_count++;
					end
					if (ipi_irq_lines !== oldest_result.ipi_irq_lines) begin
						$error("ipi_irq_lines: expected %b, got %b",
							oldest_result.ipi_irq_lines, ipi_irq_lines);
						fail_count++;
					end
					if (error !== oldest_result.error) begin
						$error("error: expected %0d, got %0d", oldest_result.error, error);
						fail_count++;
					end
				end
			end
			// hold off the output: a requested long stretch, or random short stalls
			if (hold_seen != hold_req_count) begin
				hold_seen = hold_req_count;
				stall_left = LONG_HOLD;
			end
			if (stall_left == 0 && !receiver_quiet && $urandom_range(0, 3) == 0)
				stall_left = draw_idle_cycles();
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] cpu_counts [8];
		cpu_counts = '{3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd6, 3'd4};
		for (int i = 0; i < 4; i++) shadow_mask[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed accesses at the reset CPU count
		queue_access(OP_READ, REG_CSR, 0, '1, 0, 0);
		queue_access(OP_READ, REG_MISC, 0, 0, 0, 2'd3);
		queue_access(OP_WRITE, REG_DIM, 0, '1, 0, 0);
		queue_access(OP_WRITE, REG_DIM, 3, 64'h8000_0000_0000_0000, 0, 0);
		queue_access(OP_ASSERT, REG_CSR, 0, 0, 6'd63, 0);
		queue_access(OP_ASSERT, REG_CSR, 0, 0, 6'd0, 0);
		queue_access(OP_READ, REG_DIR, 3, 0, 0, 0);
		queue_access(OP_READ, REG_DIM, 6'd63, 0, 0, 0);
		queue_access(OP_WRITE, REG_DIM, 6'd4, 64'd5, 0, 0);
		queue_access(OP_READ, REG_DRIR, 0, 0, 0, 0);
		queue_access(OP_TICK, REG_CSR, 0, 0, 0, 0);
		queue_access(OP_WRITE, REG_IPIQ, 0, '1, 0, 0);
		queue_access(OP_READ, REG_MISC, 0, 0, 0, 2'd2);
		queue_access(OP_READ, REG_ITIR, 0, 0, 0, 0);
		queue_access(OP_WRITE, REG_MISC, 0, 64'h0000_0000_0000_3A50, 0, 0);
		queue_access(OP_WRITE, REG_MISC, 0, '0, 0, 0);
		queue_access(OP_WRITE, REG_MISC, 0, DATA_W'(1) << NXM_BIT, 0, 0);
		queue_access(OP_WRITE, REG_IPIR, 0, '0, 0, 0);
		queue_access(OP_WRITE, REG_ITIR, 0, '0, 0, 0);
		queue_access(OP_WRITE, REG_IPIQ, 0, '0, 0, 0);
		queue_access(OP_WRITE, REG_IPIR, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0, 0);
		queue_access(OP_READ, REG_IPIQ, 0, 0, 0, 0);
		queue_access(OP_WRITE, REG_DIR, 0, '1, 0, 0);
		queue_access(OP_READ, REG_CODE_LAST, 0, 0, 0, 0);
		queue_access(OP_CODE_LAST, REG_MISC, 0, 0, 0, 0);
		wait_until_drained();

		// Random phases, one per CPU count; one fully quiet phase and one with a quiet sender and a long output hold
		foreach (cpu_counts[p]) begin
			write_active_cpus(cpu_counts[p]);
			sender_quiet <= (p == 2) || (p == 7);
			receiver_quiet <= (p == 2);
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_requests.push_back(random_ctl_request());
			if (p == 7) hold_req_count <= hold_req_count + 1;
			wait_until_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
